FILE: hw/rtl/ept_pkg.sv
// ----------------------------------------------------------------------------
// Eased position tween package
// Shared constants, command and state codes, and the control structures that
// pass between the sequencer and its arithmetic units.
// ----------------------------------------------------------------------------
package ept_pkg;

   localparam int POS_WIDTH    = 16;
   localparam int TIME_WIDTH   = 24;
   localparam int DELTA_WIDTH  = 16;
   localparam int MIN_DURATION = 100;

   localparam int FRAC_BITS   = 16;
   localparam int PROG_WIDTH  = FRAC_BITS + 1;
   localparam int COUNT_WIDTH = $clog2(FRAC_BITS);

   localparam int MUL_A_WIDTH = 2 * PROG_WIDTH;
   localparam int MUL_B_WIDTH = PROG_WIDTH + 1;
   localparam int MUL_P_WIDTH = MUL_A_WIDTH + MUL_B_WIDTH;

   localparam logic [PROG_WIDTH-1:0] ONE_Q = PROG_WIDTH'(1) << FRAC_BITS;
   localparam logic [TIME_WIDTH-1:0] MIN_SPAN = TIME_WIDTH'(MIN_DURATION);

   typedef enum logic [1:0] {
      CMD_START     = 2'd0,
      CMD_FROM_HERE = 2'd1,
      CMD_TICK      = 2'd2
   } cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PROG,
      S_DIV,
      S_EASE_SQ,
      S_EASE_CUBE,
      S_EASE_DONE,
      S_LERP_X,
      S_LERP_Y,
      S_LERP_END,
      S_OUT
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [TIME_WIDTH-1:0] dividend;
      logic [TIME_WIDTH-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [FRAC_BITS-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic                          load;
      logic signed [MUL_A_WIDTH-1:0] a;
      logic signed [MUL_B_WIDTH-1:0] b;
   } mul_req_type;

endpackage

FILE: hw/rtl/ept_req_if.sv
// ----------------------------------------------------------------------------
// Eased position tween command channel
// Valid/ready channel that carries one command or tick per transfer.
// ----------------------------------------------------------------------------
interface ept_req_if;
   import ept_pkg::*;

   logic                          valid;
   logic                          ready;
   cmd_type                       cmd;
   logic signed [POS_WIDTH-1:0]   from_x;
   logic signed [POS_WIDTH-1:0]   from_y;
   logic signed [POS_WIDTH-1:0]   to_x;
   logic signed [POS_WIDTH-1:0]   to_y;
   logic [TIME_WIDTH-1:0]         move_time;
   logic                          deactivate_at_end;
   logic [DELTA_WIDTH-1:0]        delta_time;

   modport source (
      output valid, cmd, from_x, from_y, to_x, to_y, move_time, deactivate_at_end,
             delta_time,
      input  ready
   );

   modport sink (
      input  valid, cmd, from_x, from_y, to_x, to_y, move_time, deactivate_at_end,
             delta_time,
      output ready
   );

endinterface

FILE: hw/rtl/ept_rsp_if.sv
// ----------------------------------------------------------------------------
// Eased position tween status channel
// Valid/ready channel that carries the position and flags after each command.
// ----------------------------------------------------------------------------
interface ept_rsp_if;
   import ept_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [POS_WIDTH-1:0] pos_x;
   logic signed [POS_WIDTH-1:0] pos_y;
   logic                        moving;
   logic                        active;

   modport source (
      output valid, pos_x, pos_y, moving, active,
      input  ready
   );

   modport sink (
      input  valid, pos_x, pos_y, moving, active,
      output ready
   );

endinterface

FILE: hw/rtl/ept_div.sv
// ----------------------------------------------------------------------------
// Progress divider
// Restoring divider that forms the Q16 fraction dividend/divisor, one quotient
// bit per cycle, for a dividend known to be smaller than the divisor.
// ----------------------------------------------------------------------------
module ept_div (
   input  logic                clock,
   input  logic                reset,
   input  ept_pkg::div_req_type div_req,
   output ept_pkg::div_rsp_type div_rsp
);
   import ept_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] LAST_STEP = COUNT_WIDTH'(FRAC_BITS - 1);

   logic                   running_ff, running_in;
   logic                   done_ff, done_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [TIME_WIDTH-1:0]  rem_ff, rem_in;
   logic [TIME_WIDTH-1:0]  divisor_ff, divisor_in;
   logic [FRAC_BITS-1:0]   quo_ff, quo_in;
   logic [TIME_WIDTH:0]    shifted;
   logic [TIME_WIDTH:0]    diff;
   logic                   fits;

   always_comb begin
      shifted    = {rem_ff, 1'b0};
      diff       = shifted - {1'b0, divisor_ff};
      fits       = shifted >= {1'b0, divisor_ff};
      running_in = running_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      if (div_req.start) begin
         running_in = 1'b1;
         count_in   = '0;
         rem_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (running_ff) begin
         rem_in   = fits ? diff[TIME_WIDTH-1:0] : shifted[TIME_WIDTH-1:0];
         quo_in   = {quo_ff[FRAC_BITS-2:0], fits};
         count_in = count_ff + COUNT_WIDTH'(1);
         if (count_ff == LAST_STEP) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   // The partial remainder stays below the divisor, so every quotient bit is 0 or 1.
   assert property (@(posedge clock) disable iff (reset) running_ff |-> rem_ff < divisor_ff)
      else $error("divider remainder reached the divisor");

   // The sequencer never restarts a division that is still in progress.
   assert property (@(posedge clock) disable iff (reset) div_req.start |-> !running_ff)
      else $error("divider restarted while busy");

endmodule

FILE: hw/rtl/ept_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiplier with a registered product, used in turn for the easing
// cube and the two interpolation steps.
// ----------------------------------------------------------------------------
module ept_mul (
   input  logic                                    clock,
   input  ept_pkg::mul_req_type                    mul_req,
   output logic signed [ept_pkg::MUL_P_WIDTH-1:0] product
);
   import ept_pkg::*;

   logic signed [MUL_P_WIDTH-1:0] product_ff, product_in;

   always_comb begin
      product_in = product_ff;
      if (mul_req.load) begin
         product_in = MUL_P_WIDTH'(mul_req.a) * MUL_P_WIDTH'(mul_req.b);
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

FILE: hw/rtl/eased_position_tween.sv
// ----------------------------------------------------------------------------
// Eased position tween
// Moves a 2-D point from a start to a target over a set duration, optionally
// with ease-out cubic progress.
//
// Commands arrive on req_chan; each accepted command gives exactly one status
// transfer on rsp_chan with the position and the moving and active flags.
// A start or move-from-here command, an unused command code, and a tick while
// no move is running go straight from idle to the output state.
// A tick during a move passes through the progress state, the bit-serial progress
// divider, the easing states when easing is on, and the interpolation states
// before the output state. A tick that finishes the move skips the divider.
// One command is worked on at a time: req_chan.ready is high only while the
// sequencer is idle, and it rises in the cycle the status becomes valid.
// A status that the receiver stalls is held in the output register; the next
// command can be accepted meanwhile, and its status waits until the held one
// is taken.
// Reset puts the point at the origin, idle and active, with linear progress.
// csr_we writes the easing enable from csr_wdata; the user must write it only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module eased_position_tween (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_we,
   input  logic      csr_wdata,
   ept_req_if.sink   req_chan,
   ept_rsp_if.source rsp_chan
);
   import ept_pkg::*;

   state_type                     state_ff, state_in;
   logic                          use_easing_ff, use_easing_in;
   logic signed [POS_WIDTH-1:0]   origin_x_ff, origin_x_in, origin_y_ff, origin_y_in;
   logic signed [POS_WIDTH-1:0]   goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic signed [POS_WIDTH-1:0]   cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [TIME_WIDTH-1:0]         elapsed_ff, elapsed_in, span_ff, span_in;
   logic                          end_deact_ff, end_deact_in;
   logic                          busy_ff, busy_in, active_ff, active_in;
   logic [PROG_WIDTH-1:0]         t_ff, t_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [POS_WIDTH-1:0]   rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                          rsp_moving_ff, rsp_moving_in;
   logic                          rsp_active_ff, rsp_active_in;

   logic                          accept;
   logic [TIME_WIDTH:0]           elapsed_sum;
   logic [TIME_WIDTH-1:0]         span_new;
   logic [PROG_WIDTH-1:0]         inv;
   logic signed [POS_WIDTH:0]     dx, dy;
   logic [POS_WIDTH-1:0]          step;
   logic [PROG_WIDTH-1:0]         cube;
   logic signed [MUL_P_WIDTH-1:0] product;
   div_req_type                   div_req;
   div_rsp_type                   div_rsp;
   mul_req_type                   mul_req;

   ept_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   ept_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .product (product)
   );

   assign req_chan.ready  = (state_ff == S_IDLE);
   assign accept          = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.pos_x  = rsp_x_ff;
   assign rsp_chan.pos_y  = rsp_y_ff;
   assign rsp_chan.moving = rsp_moving_ff;
   assign rsp_chan.active = rsp_active_ff;

   always_comb begin
      elapsed_sum = {1'b0, elapsed_ff} + (TIME_WIDTH + 1)'(req_chan.delta_time);
      span_new    = (req_chan.move_time < MIN_SPAN) ? MIN_SPAN : req_chan.move_time;
      inv         = ONE_Q - t_ff;
      dx          = {goal_x_ff[POS_WIDTH-1], goal_x_ff} - {origin_x_ff[POS_WIDTH-1], origin_x_ff};
      dy          = {goal_y_ff[POS_WIDTH-1], goal_y_ff} - {origin_y_ff[POS_WIDTH-1], origin_y_ff};
      step        = product[POS_WIDTH+FRAC_BITS-1:FRAC_BITS];
      cube        = product[2*FRAC_BITS+PROG_WIDTH-1:2*FRAC_BITS];

      state_in      = state_ff;
      use_easing_in = csr_we ? csr_wdata : use_easing_ff;
      origin_x_in   = origin_x_ff;
      origin_y_in   = origin_y_ff;
      goal_x_in     = goal_x_ff;
      goal_y_in     = goal_y_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      elapsed_in    = elapsed_ff;
      span_in       = span_ff;
      end_deact_in  = end_deact_ff;
      busy_in       = busy_ff;
      active_in     = active_ff;
      t_in          = t_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_moving_in = rsp_moving_ff;
      rsp_active_in = rsp_active_ff;

      div_req.start    = 1'b0;
      div_req.dividend = elapsed_ff;
      div_req.divisor  = span_ff;
      mul_req.load     = 1'b0;
      mul_req.a        = '0;
      mul_req.b        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_OUT;
               unique case (req_chan.cmd)
                  CMD_START, CMD_FROM_HERE: begin
                     if (req_chan.cmd == CMD_START) begin
                        origin_x_in = req_chan.from_x;
                        origin_y_in = req_chan.from_y;
                        cur_x_in    = req_chan.from_x;
                        cur_y_in    = req_chan.from_y;
                     end else begin
                        origin_x_in = cur_x_ff;
                        origin_y_in = cur_y_ff;
                     end
                     goal_x_in    = req_chan.to_x;
                     goal_y_in    = req_chan.to_y;
                     span_in      = span_new;
                     elapsed_in   = '0;
                     end_deact_in = req_chan.deactivate_at_end;
                     busy_in      = 1'b1;
                     active_in    = 1'b1;
                  end
                  CMD_TICK: begin
                     if (busy_ff) begin
                        elapsed_in = elapsed_sum[TIME_WIDTH] ? '1
                                                             : elapsed_sum[TIME_WIDTH-1:0];
                        state_in   = S_PROG;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_PROG: begin
            if (elapsed_ff >= span_ff) begin
               t_in     = ONE_Q;
               state_in = use_easing_ff ? S_EASE_SQ : S_LERP_X;
            end else begin
               div_req.start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               t_in     = PROG_WIDTH'(div_rsp.quotient);
               state_in = use_easing_ff ? S_EASE_SQ : S_LERP_X;
            end
         end
         S_EASE_SQ: begin
            mul_req.load = 1'b1;
            mul_req.a    = MUL_A_WIDTH'(inv);
            mul_req.b    = MUL_B_WIDTH'(inv);
            state_in     = S_EASE_CUBE;
         end
         S_EASE_CUBE: begin
            mul_req.load = 1'b1;
            mul_req.a    = product[MUL_A_WIDTH-1:0];
            mul_req.b    = MUL_B_WIDTH'(inv);
            state_in     = S_EASE_DONE;
         end
         S_EASE_DONE: begin
            t_in     = ONE_Q - cube;
            state_in = S_LERP_X;
         end
         S_LERP_X: begin
            mul_req.load = 1'b1;
            mul_req.a    = MUL_A_WIDTH'(dx);
            mul_req.b    = MUL_B_WIDTH'(t_ff);
            state_in     = S_LERP_Y;
         end
         S_LERP_Y: begin
            cur_x_in     = origin_x_ff + step;
            mul_req.load = 1'b1;
            mul_req.a    = MUL_A_WIDTH'(dy);
            mul_req.b    = MUL_B_WIDTH'(t_ff);
            state_in     = S_LERP_END;
         end
         S_LERP_END: begin
            cur_y_in = origin_y_ff + step;
            if (elapsed_ff >= span_ff) begin
               busy_in = 1'b0;
               if (end_deact_ff) begin
                  active_in = 1'b0;
               end
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_x_in      = cur_x_ff;
               rsp_y_in      = cur_y_ff;
               rsp_moving_in = busy_ff;
               rsp_active_in = active_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         use_easing_ff <= 1'b0;
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         goal_x_ff     <= '0;
         goal_y_ff     <= '0;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         elapsed_ff    <= '0;
         span_ff       <= MIN_SPAN;
         end_deact_ff  <= 1'b0;
         busy_ff       <= 1'b0;
         active_ff     <= 1'b1;
         t_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         use_easing_ff <= use_easing_in;
         origin_x_ff   <= origin_x_in;
         origin_y_ff   <= origin_y_in;
         goal_x_ff     <= goal_x_in;
         goal_y_ff     <= goal_y_in;
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         elapsed_ff    <= elapsed_in;
         span_ff       <= span_in;
         end_deact_ff  <= end_deact_in;
         busy_ff       <= busy_in;
         active_ff     <= active_in;
         t_ff          <= t_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_moving_ff <= rsp_moving_in;
      rsp_active_ff <= rsp_active_in;
   end

   // Progress never exceeds one in Q16.
   assert property (@(posedge clock) disable iff (reset) t_ff <= ONE_Q)
      else $error("progress above one");

   // The stored duration is never below the minimum.
   assert property (@(posedge clock) disable iff (reset) span_ff >= MIN_SPAN)
      else $error("duration below minimum");

   // A move only ends once the elapsed time has reached the duration.
   assert property (@(posedge clock) disable iff (reset)
                    (!$past(reset) && $fell(busy_ff)) |-> elapsed_ff >= span_ff)
      else $error("move ended early");

endmodule

FILE: verif/ept_tween_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Eased position tween status checker
// Watches the command channel, the status channel and the easing register
// write. It keeps its own model of the tween, predicts the status for every
// accepted command and compares each status transfer, field by field, with the
// oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module ept_tween_checker (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic csr_wdata,
   ept_req_if   req_mon,
   ept_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   checked,
   output int   finishes
);
   import ept_pkg::*;

   typedef struct packed {
      logic signed [POS_WIDTH-1:0] pos_x;
      logic signed [POS_WIDTH-1:0] pos_y;
      logic                        moving;
      logic                        active;
   } status_type;

   localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

   logic signed [POS_WIDTH-1:0] origin_x, origin_y, goal_x, goal_y, point_x, point_y;
   logic [TIME_WIDTH-1:0]       elapsed, span;
   logic [TIME_WIDTH:0]         elapsed_sum;
   logic [PROG_WIDTH-1:0]       progress;
   logic                        end_deactivate, busy, active, easing;
   status_type                  expected_status[$];
   status_type                  seen, predicted;

   function automatic logic [PROG_WIDTH-1:0] progress_q16(
      input logic [TIME_WIDTH-1:0] done_time,
      input logic [TIME_WIDTH-1:0] total,
      input logic                  eased
   );
      longint unsigned frac;
      longint unsigned rest;
      frac = (64'(done_time) << FRAC_BITS) / 64'(total);
      if (frac > 64'(ONE_Q)) frac = 64'(ONE_Q);
      if (eased) begin
         rest = 64'(ONE_Q) - frac;
         frac = 64'(ONE_Q) - ((rest * rest * rest) >> 32);
      end
      return PROG_WIDTH'(frac);
   endfunction

   // The step is rounded toward minus infinity, so it never leaves the span.
   function automatic logic signed [POS_WIDTH-1:0] interp(
      input logic signed [POS_WIDTH-1:0] from_pt,
      input logic signed [POS_WIDTH-1:0] to_pt,
      input logic [PROG_WIDTH-1:0]       frac
   );
      longint step;
      step = (longint'(to_pt) - longint'(from_pt)) * longint'(frac);
      return POS_WIDTH'(longint'(from_pt) + (step >>> FRAC_BITS));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         origin_x       = '0;
         origin_y       = '0;
         goal_x         = '0;
         goal_y         = '0;
         point_x        = '0;
         point_y        = '0;
         elapsed        = '0;
         span           = MIN_SPAN;
         end_deactivate = 1'b0;
         busy           = 1'b0;
         active         = 1'b1;
         easing         = 1'b0;
         fail_count     = 0;
         checked        = 0;
         finishes       = 0;
         expected_status.delete();
      end else begin
         if (csr_we) easing = csr_wdata;

         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.pos_x  = rsp_mon.pos_x;
            seen.pos_y  = rsp_mon.pos_y;
            seen.moving = rsp_mon.moving;
            seen.active = rsp_mon.active;
            checked++;
            if (expected_status.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("ERROR: %0d ns: unexpected status x=%0d y=%0d moving=%0b active=%0b",
                           $time, seen.pos_x, seen.pos_y, seen.moving, seen.active);
            end else begin
               predicted = expected_status.pop_front();
               if (seen.pos_x !== predicted.pos_x || seen.pos_y !== predicted.pos_y ||
                   seen.moving !== predicted.moving || seen.active !== predicted.active) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("ERROR: %0d ns: expected x=%0d y=%0d moving=%0b active=%0b, %s",
                              $time, predicted.pos_x, predicted.pos_y, predicted.moving,
                              predicted.active,
                              $sformatf("got x=%0d y=%0d moving=%0b active=%0b",
                                        seen.pos_x, seen.pos_y, seen.moving, seen.active));
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.cmd)
               CMD_START, CMD_FROM_HERE: begin
                  if (req_mon.cmd == CMD_START) begin
                     origin_x = req_mon.from_x;
                     origin_y = req_mon.from_y;
                  end else begin
                     origin_x = point_x;
                     origin_y = point_y;
                  end
                  goal_x         = req_mon.to_x;
                  goal_y         = req_mon.to_y;
                  span           = (req_mon.move_time < MIN_SPAN) ? MIN_SPAN : req_mon.move_time;
                  elapsed        = '0;
                  end_deactivate = req_mon.deactivate_at_end;
                  busy           = 1'b1;
                  active         = 1'b1;
                  point_x        = origin_x;
                  point_y        = origin_y;
               end
               CMD_TICK: begin
                  if (busy) begin
                     elapsed_sum = {1'b0, elapsed} + req_mon.delta_time;
                     elapsed     = elapsed_sum[TIME_WIDTH] ? TIME_MAX
                                                           : elapsed_sum[TIME_WIDTH-1:0];
                     progress    = progress_q16(elapsed, span, easing);
                     point_x     = interp(origin_x, goal_x, progress);
                     point_y     = interp(origin_y, goal_y, progress);
                     if (elapsed >= span) begin
                        busy = 1'b0;
                        finishes++;
                        if (end_deactivate) active = 1'b0;
                     end
                  end
               end
               default: begin
               end
            endcase
            predicted.pos_x  = point_x;
            predicted.pos_y  = point_y;
            predicted.moving = busy;
            predicted.active = active;
            expected_status.push_back(predicted);
         end
      end
      pending = expected_status.size();
   end

endmodule

FILE: verif/eased_position_tween_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Eased position tween testbench
// Drives directed and random move sequences into the tween, with random gaps
// on the command side and random stalls on the status side, one long status
// hold-off, and both easing settings. A separate checker predicts and compares
// every status transfer; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module eased_position_tween_tb;
   import ept_pkg::*;

   localparam cmd_type CMD_UNUSED = cmd_type'(2'd3);
   localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};
   localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
   localparam logic [TIME_WIDTH-1:0]  TIME_MAX      = '1;
   localparam logic [DELTA_WIDTH-1:0] DELTA_MAX     = '1;
   localparam int                     CYCLE_LIMIT   = 400000;
   localparam int                     HOLD_CYCLES   = 300;
   localparam int                     SETTLE_CYCLES = 40;
   localparam int                     PHASE_ITEMS   = 30;

   logic clock     = 1'b0;
   logic reset     = 1'b1;
   logic csr_we    = 1'b0;
   logic csr_wdata = 1'b0;

   ept_req_if req_chan ();
   ept_rsp_if rsp_chan ();

   int fail_count, pending, checked, finishes;
   int cycle_count = 0;
   int worked      = 0;
   int csr_writes  = 0;
   int sent[4]     = '{default: 0};
   bit gaps_on     = 1'b1;
   bit stalls_on   = 1'b1;
   bit hold_long   = 1'b0;

   eased_position_tween i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   ept_tween_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked),
      .finishes   (finishes)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d status transfers outstanding",
                  cycle_count, pending);
         $display("FAIL");
         $finish;
      end
   end

   // Status receiver: random stalls, and one long hold-off on request.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_long) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_long = 1'b0;
            rsp_chan.ready <= 1'b1;
         end else if (stalls_on && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   function automatic logic signed [POS_WIDTH-1:0] rand_pos();
      return POS_WIDTH'($urandom);
   endfunction

   // Entered and left at a falling edge; valid stays high after the transfer.
   task automatic issue(
      input cmd_type                     code,
      input logic signed [POS_WIDTH-1:0] fx,
      input logic signed [POS_WIDTH-1:0] fy,
      input logic signed [POS_WIDTH-1:0] tx,
      input logic signed [POS_WIDTH-1:0] ty,
      input logic [TIME_WIDTH-1:0]       duration,
      input logic                        deactivate,
      input logic [DELTA_WIDTH-1:0]      delta
   );
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_chan.valid             <= 1'b1;
      req_chan.cmd               <= code;
      req_chan.from_x            <= fx;
      req_chan.from_y            <= fy;
      req_chan.to_x              <= tx;
      req_chan.to_y              <= ty;
      req_chan.move_time         <= duration;
      req_chan.deactivate_at_end <= deactivate;
      req_chan.delta_time        <= delta;
      do @(posedge clock); while (!req_chan.ready);
      sent[int'(code)]++;
      @(negedge clock);
   endtask

   task automatic write_easing(input logic enable);
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= enable;
      @(negedge clock);
      csr_we <= 1'b0;
      csr_writes++;
   endtask

   // A start or move-from-here followed by ticks until the move should end,
   // with some unused codes mixed in and some moves abandoned part way.
   task automatic random_move();
      cmd_type                code;
      logic [TIME_WIDTH-1:0]  duration;
      logic [TIME_WIDTH-1:0]  span;
      logic [DELTA_WIDTH-1:0] delta;
      longint                 run;
      int                     step_max;
      int                     ticks;
      int                     pick;
      bit                     abandon;
      code = ($urandom_range(0, 1) == 0) ? CMD_START : CMD_FROM_HERE;
      pick = $urandom_range(0, 19);
      if (pick < 3) duration = TIME_WIDTH'($urandom_range(0, MIN_DURATION));
      else if (pick < 17) duration = TIME_WIDTH'($urandom_range(MIN_DURATION, 4000));
      else if (pick < 19) duration = TIME_WIDTH'($urandom_range(4001, 300000));
      else duration = TIME_WIDTH'($urandom);
      span     = (duration < MIN_SPAN) ? MIN_SPAN : duration;
      step_max = (span / 3 >= 65535) ? 65535 : int'(span / 3) + 1;
      issue(code, rand_pos(), rand_pos(), rand_pos(), rand_pos(), duration, 1'($urandom),
            DELTA_WIDTH'($urandom));
      worked++;
      run     = 0;
      ticks   = 0;
      abandon = 1'b0;
      while (run < longint'(span) && ticks < 12 && !abandon) begin
         pick = $urandom_range(0, 29);
         if (pick == 0) begin
            issue(CMD_UNUSED, rand_pos(), rand_pos(), rand_pos(), rand_pos(),
                  TIME_WIDTH'($urandom), 1'($urandom), DELTA_WIDTH'($urandom));
         end else if (pick == 1) begin
            abandon = 1'b1;
         end else begin
            delta = (pick == 2) ? DELTA_WIDTH'($urandom)
                                : DELTA_WIDTH'($urandom_range(0, step_max));
            issue(CMD_TICK, rand_pos(), rand_pos(), rand_pos(), rand_pos(),
                  TIME_WIDTH'($urandom), 1'($urandom), delta);
            run += longint'(delta);
            ticks++;
            worked++;
         end
      end
      if ($urandom_range(0, 3) == 0)
         issue(CMD_TICK, rand_pos(), rand_pos(), rand_pos(), rand_pos(),
               TIME_WIDTH'($urandom), 1'($urandom), DELTA_WIDTH'($urandom));
   endtask

   initial begin
      longint run;
      req_chan.valid             = 1'b0;
      req_chan.cmd               = CMD_START;
      req_chan.from_x            = '0;
      req_chan.from_y            = '0;
      req_chan.to_x              = '0;
      req_chan.to_y              = '0;
      req_chan.move_time         = '0;
      req_chan.deactivate_at_end = 1'b0;
      req_chan.delta_time        = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_easing(1'b0);
      issue(CMD_TICK, '0, '0, '0, '0, '0, 1'b0, DELTA_WIDTH'(1234));
      issue(CMD_UNUSED, POS_MAX, POS_MAX, POS_MAX, POS_MAX, TIME_MAX, 1'b1, DELTA_MAX);
      issue(CMD_START, POS_MIN, POS_MAX, POS_MAX, POS_MIN, '0, 1'b1, '0);
      issue(CMD_TICK, '0, '0, '0, '0, '0, 1'b0, '0);
      issue(CMD_TICK, '0, '0, '0, '0, '0, 1'b0, DELTA_WIDTH'(50));
      issue(CMD_TICK, '0, '0, '0, '0, '0, 1'b0, DELTA_MAX);
      issue(CMD_TICK, '0, '0, '0, '0, '0, 1'b0, DELTA_WIDTH'(7));
      issue(CMD_FROM_HERE, POS_MAX, POS_MAX, '0, '0, TIME_MAX, 1'b0, '0);
      issue(CMD_TICK, '0, '0, '0, '0, '0, 1'b0, DELTA_MAX);
      issue(CMD_UNUSED, '0, '0, '0, '0, '0, 1'b0, '0);
      issue(CMD_START, POS_MAX, POS_MIN, POS_MIN, POS_MAX, TIME_WIDTH'(99), 1'b1, '0);
      issue(CMD_TICK, '0, '0, '0, '0, '0, 1'b0, DELTA_WIDTH'(1));
      issue(CMD_TICK, '0, '0, '0, '0, '0, 1'b0, DELTA_WIDTH'(98));
      issue(CMD_TICK, '0, '0, '0, '0, '0, 1'b0, DELTA_WIDTH'(1));

      write_easing(1'b1);
      issue(CMD_START, POS_MIN, POS_MIN, POS_MAX, POS_MAX, TIME_WIDTH'(100), 1'b0, '0);
      issue(CMD_TICK, '0, '0, '0, '0, '0, 1'b0, DELTA_WIDTH'(1));
      issue(CMD_TICK, '0, '0, '0, '0, '0, 1'b0, DELTA_WIDTH'(33));
      issue(CMD_TICK, '0, '0, '0, '0, '0, 1'b0, DELTA_WIDTH'(66));
      issue(CMD_FROM_HERE, '0, '0, '0, '0, TIME_WIDTH'(1000), 1'b1, '0);
      issue(CMD_TICK, '0, '0, '0, '0, '0, 1'b0, DELTA_WIDTH'(500));
      issue(CMD_TICK, '0, '0, '0, '0, '0, 1'b0, DELTA_MAX);

      // The longest move, ticked at the largest step until the elapsed time
      // saturates at the top of its range.
      issue(CMD_START, POS_MIN, POS_MAX, POS_MAX, POS_MIN, TIME_MAX, 1'b1, '0);
      for (run = 0; run < longint'(TIME_MAX); run += longint'(DELTA_MAX))
         issue(CMD_TICK, '0, '0, '0, '0, '0, 1'b0, DELTA_MAX);

      for (int phase = 0; phase < 4; phase++) begin
         write_easing(phase[0]);
         if (phase == 1) hold_long = 1'b1;
         if (phase == 3) begin
            gaps_on   = 1'b0;
            stalls_on = 1'b0;
         end
         worked = 0;
         while (worked < PHASE_ITEMS) random_move();
      end

      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Checked %0d status transfers: %0d starts, %0d moves from here, %0d ticks, %s",
               checked, sent[int'(CMD_START)], sent[int'(CMD_FROM_HERE)],
               sent[int'(CMD_TICK)], $sformatf("%0d unused codes.", sent[int'(CMD_UNUSED)]));
      $display("%0d moves ran to their end; %0d easing writes; one %0d-cycle status hold-off.",
               finishes, csr_writes, HOLD_CYCLES);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
